// ----- hdl/gf16mi_pkg.sv -----
// shared types, codes and field arithmetic for the gf(2^16) multiply / invert unit
`timescale 1ns / 1ps

package gf16mi_pkg;

    // field element width and low bits of x^16 + x^5 + x^3 + x + 1
    localparam int          ELEM_W   = 16;
    localparam logic [15:0] POLY_LOW = 16'h002b;

    // action codes carried in tuser
    localparam logic ACT_MUL = 1'b0;
    localparam logic ACT_INV = 1'b1;

    // stage operand source codes
    localparam int SRC_A  = 0;
    localparam int SRC_X2 = 1;
    localparam int SRC_X4 = 2;

    // stage save target codes
    localparam int SAVE_NONE = 0;
    localparam int SAVE_X2   = 1;
    localparam int SAVE_X4   = 2;

    // request as it moves down the pipeline
    typedef struct packed {
        logic        act;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] x2;
        logic [15:0] x4;
        logic [15:0] cur;
    } t_stage_data;

    // reduce a 31-bit carry-less product, two folds since the polynomial tail is short
    function automatic logic [15:0] gf_reduce(input logic [30:0] p);
        logic [19:0] h1;
        logic [19:0] t;
        logic [15:0] h2;
        logic [15:0] r;
        h1 = {5'd0, p[30:16]};
        t  = {4'd0, p[15:0]} ^ h1 ^ (h1 << 1) ^ (h1 << 3) ^ (h1 << 5);
        h2 = {12'd0, t[19:16]};
        r  = t[15:0] ^ h2 ^ (h2 << 1) ^ (h2 << 3) ^ (h2 << 5);
        return r;
    endfunction

    // full field multiply: independent partial products, then reduction
    function automatic logic [15:0] gf_mul(input logic [15:0] x, input logic [15:0] y);
        logic [30:0] p;
        p = '0;
        for (int i = 0; i < ELEM_W; i++) begin
            if (y[i]) begin
                p = p ^ ({15'd0, x} << i);
            end
        end
        return gf_reduce(p);
    endfunction

    // squaring is linear: spread bits to even positions and reduce
    function automatic logic [15:0] gf_sq(input logic [15:0] v);
        logic [30:0] p;
        p = '0;
        for (int i = 0; i < ELEM_W; i++) begin
            p[2*i] = v[i];
        end
        return gf_reduce(p);
    endfunction

    // repeated squaring, v^(2^n), n is a small elaboration constant
    function automatic logic [15:0] gf_sq_n(input logic [15:0] v, input int n);
        logic [15:0] r;
        r = v;
        for (int i = 0; i < n; i++) begin
            r = gf_sq(r);
        end
        return r;
    endfunction

endpackage

// ----- hdl/gf16mi_stage.sv -----
// one multiplier stage of the inversion chain, also carries multiply requests
`timescale 1ns / 1ps

module gf16mi_stage #(
    parameter int SQ_N     = 1,
    parameter int SRC      = gf16mi_pkg::SRC_A,
    parameter int SAVE     = gf16mi_pkg::SAVE_NONE,
    parameter bit MUL_HERE = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  gf16mi_pkg::t_stage_data i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    output gf16mi_pkg::t_stage_data o_data,
    input  logic                    i_ready
);

    logic                    r_valid;
    gf16mi_pkg::t_stage_data r_data;
    gf16mi_pkg::t_stage_data n_data;
    logic [15:0]             w_src;
    logic [15:0]             w_opx;
    logic [15:0]             w_opy;
    logic [15:0]             w_prod;
    logic                    w_inv;

    assign w_inv = (i_data.act == gf16mi_pkg::ACT_INV);

    // pick the saved power this step multiplies by
    always_comb begin
        case (SRC)
            gf16mi_pkg::SRC_X2: w_src = i_data.x2;
            gf16mi_pkg::SRC_X4: w_src = i_data.x4;
            default:            w_src = i_data.a;
        endcase
    end

    // one field multiply per stage
    assign w_opx  = w_inv ? gf16mi_pkg::gf_sq_n(i_data.cur, SQ_N) : i_data.cur;
    assign w_opy  = w_inv ? w_src : i_data.b;
    assign w_prod = gf16mi_pkg::gf_mul(w_opx, w_opy);

    // next payload: inverse chain step, or the product in the multiply stage
    always_comb begin
        n_data = i_data;
        if (w_inv) begin
            n_data.cur = w_prod;
            case (SAVE)
                gf16mi_pkg::SAVE_X2: n_data.x2 = w_prod;
                gf16mi_pkg::SAVE_X4: n_data.x4 = w_prod;
                default:             n_data.x2 = i_data.x2;
            endcase
        end else if (MUL_HERE) begin
            n_data.cur = w_prod;
        end
    end

    // stage moves when empty or when downstream takes
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/gf16mi_out.sv -----
// output register: final squaring for inverse, product passes through
`timescale 1ns / 1ps

module gf16mi_out (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  gf16mi_pkg::t_stage_data i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    output logic [15:0]             o_result,
    input  logic                    i_ready
);

    logic        r_valid;
    logic [15:0] r_result;
    logic [15:0] n_result;

    // a^(2^15-1) squared gives a^(2^16-2)
    assign n_result = (i_data.act == gf16mi_pkg::ACT_INV) ? gf16mi_pkg::gf_sq(i_data.cur)
                                                          : i_data.cur;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hdl/gf2_16_mul_inv_unit.sv -----
// top level of the gf(2^16) multiply / invert unit
`timescale 1ns / 1ps

// Field arithmetic over GF(2^16), polynomial x^16 + x^5 + x^3 + x + 1.
// Request channel (s_axis): tuser is the action (0 multiply, 1 invert),
// tdata holds operand a in bits 15:0 and operand b in bits 31:16.
// Result channel (m_axis): tdata holds the 16-bit product or inverse.
// Invert computes a^(2^16-2) with an addition chain of six multiplies,
// one multiplier per stage; the inverse of zero is zero. Multiply uses the
// first stage's multiplier and rides along the rest of the chain.
// Seven register stages (six multiplier stages and the output register) lie
// between an accepted request and its result. Throughput: one request per
// cycle while m_axis_tready is high; a held result stalls the chain.
// Reset empties the pipeline (all valid bits cleared); nothing else is kept.
// When m_axis_tready is low, stages fill behind the held result and
// s_axis_tready drops only once the pipeline is full; nothing is lost.

module gf2_16_mul_inv_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // operand_a[15:0], operand_b[31:16]
    input  logic        s_axis_tuser,   // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // field_result[15:0]
);

    localparam int NSTG = 6;

    // per-stage operand source, save target and square count of the chain
    localparam int SQ_TAB   [NSTG] = '{1, 2, 4, 4, 2, 1};
    localparam int SRC_TAB  [NSTG] = '{gf16mi_pkg::SRC_A,  gf16mi_pkg::SRC_X2,
                                       gf16mi_pkg::SRC_X4, gf16mi_pkg::SRC_X4,
                                       gf16mi_pkg::SRC_X2, gf16mi_pkg::SRC_A};
    localparam int SAVE_TAB [NSTG] = '{gf16mi_pkg::SAVE_X2,   gf16mi_pkg::SAVE_X4,
                                       gf16mi_pkg::SAVE_NONE, gf16mi_pkg::SAVE_NONE,
                                       gf16mi_pkg::SAVE_NONE, gf16mi_pkg::SAVE_NONE};

    logic                    w_valid [NSTG+1];
    logic                    w_ready [NSTG+1];
    gf16mi_pkg::t_stage_data w_data  [NSTG+1];

    // unpack the request into the pipeline record
    always_comb begin
        w_data[0]     = '0;
        w_data[0].act = s_axis_tuser;
        w_data[0].a   = s_axis_tdata[15:0];
        w_data[0].b   = s_axis_tdata[31:16];
        w_data[0].cur = s_axis_tdata[15:0];
    end
    assign w_valid[0]    = s_axis_tvalid;
    assign s_axis_tready = w_ready[0];

    // multiplier chain: x2, x4, x8, x12, x14, x15 powers of a
    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        gf16mi_stage #(
            .SQ_N     (SQ_TAB[g]),
            .SRC      (SRC_TAB[g]),
            .SAVE     (SAVE_TAB[g]),
            .MUL_HERE (g == 0)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    // final square and result register
    gf16mi_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[NSTG]),
        .i_data   (w_data[NSTG]),
        .o_ready  (w_ready[NSTG]),
        .o_valid  (m_axis_tvalid),
        .o_result (m_axis_tdata),
        .i_ready  (m_axis_tready)
    );

endmodule

// ----- verif/gf16mi_result_checker.sv -----
// result checker for the gf(2^16) multiply / invert unit: predicts each request, compares results
`timescale 1ns / 1ps

module gf16mi_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // operand_a[15:0], operand_b[31:16]
    input  logic        s_axis_tuser,   // action[0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // field_result[15:0]
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_mul_count,
    output int          o_inv_count,
    output int          o_input_stall_cycles
);

    // exponent 2^16 - 2 gives the inverse, and maps zero to zero
    localparam logic [15:0] INV_EXP = 16'hfffe;

    // request kept with its predicted field element
    typedef struct {
        logic        act;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] field_result;
    } t_predicted_op;

    t_predicted_op predicted_ops[$];

    int fail_count;
    int outstanding;
    int mul_count;
    int inv_count;
    int input_stall_cycles;

    assign o_fail_count         = fail_count;
    assign o_outstanding        = outstanding;
    assign o_mul_count          = mul_count;
    assign o_inv_count          = inv_count;
    assign o_input_stall_cycles = input_stall_cycles;

    // multiply by x with reduction by the field polynomial
    function automatic logic [15:0] times_x(input logic [15:0] v);
        return {v[14:0], 1'b0} ^ (v[15] ? gf16mi_pkg::POLY_LOW : 16'h0000);
    endfunction

    // shift-and-add product, reducing as the multiplicand is shifted
    function automatic logic [15:0] field_product(input logic [15:0] x, input logic [15:0] y);
        logic [15:0] acc;
        logic [15:0] shifted;
        acc     = '0;
        shifted = x;
        for (int i = 0; i < gf16mi_pkg::ELEM_W; i++) begin
            if (y[i]) begin
                acc = acc ^ shifted;
            end
            shifted = times_x(shifted);
        end
        return acc;
    endfunction

    // left-to-right square and multiply of x^(2^16 - 2)
    function automatic logic [15:0] field_inverse(input logic [15:0] x);
        logic [15:0] r;
        r = 16'h0001;
        for (int i = gf16mi_pkg::ELEM_W - 1; i >= 0; i--) begin
            r = field_product(r, r);
            if (INV_EXP[i]) begin
                r = field_product(r, x);
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] field_op_result(input logic act, input logic [15:0] a,
                                                    input logic [15:0] b);
        if (act == gf16mi_pkg::ACT_INV) begin
            return field_inverse(a);
        end
        return field_product(a, b);
    endfunction

    initial begin
        fail_count         = 0;
        outstanding        = 0;
        mul_count          = 0;
        inv_count          = 0;
        input_stall_cycles = 0;
    end

    // results are checked before new requests are queued in the same cycle
    always @(posedge i_clk) begin
        t_predicted_op op;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_ops.size() == 0) begin
                    $display("%0t: result %h with no request outstanding", $realtime,
                             m_axis_tdata);
                    fail_count++;
                end else begin
                    op = predicted_ops.pop_front();
                    outstanding--;
                    if (m_axis_tdata !== op.field_result) begin
                        $display("%0t: %s a=%h b=%h field_result expected %h actual %h",
                                 $realtime, (op.act == gf16mi_pkg::ACT_INV) ? "inv" : "mul",
                                 op.a, op.b, op.field_result, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                op.act          = s_axis_tuser;
                op.a            = s_axis_tdata[15:0];
                op.b            = s_axis_tdata[31:16];
                op.field_result = field_op_result(op.act, op.a, op.b);
                predicted_ops.push_back(op);
                outstanding++;
                if (op.act == gf16mi_pkg::ACT_INV) begin
                    inv_count++;
                end else begin
                    mul_count++;
                end
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                input_stall_cycles++;
            end
        end
    end

endmodule

// ----- verif/tb_gf2_16_mul_inv_unit.sv -----
// testbench top for the gf(2^16) multiply / invert unit: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_gf2_16_mul_inv_unit;

    localparam int RANDOM_OPS     = 1400;
    localparam int BURST_OPS      = 64;
    localparam int LONG_HOLD      = 120;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // operand_a[15:0], operand_b[31:16]
    logic        s_axis_tuser;   // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // field_result[15:0]

    int fail_count;
    int outstanding;
    int mul_count;
    int inv_count;
    int input_stall_cycles;

    // handshake between the burst phase and the receiver's long hold
    logic long_hold_req  = 1'b0;
    logic long_hold_on   = 1'b0;
    logic long_hold_done = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    gf2_16_mul_inv_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gf16mi_result_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .s_axis_tvalid        (s_axis_tvalid),
        .s_axis_tready        (s_axis_tready),
        .s_axis_tdata         (s_axis_tdata),
        .s_axis_tuser         (s_axis_tuser),
        .m_axis_tvalid        (m_axis_tvalid),
        .m_axis_tready        (m_axis_tready),
        .m_axis_tdata         (m_axis_tdata),
        .o_fail_count         (fail_count),
        .o_outstanding        (outstanding),
        .o_mul_count          (mul_count),
        .o_inv_count          (inv_count),
        .o_input_stall_cycles (input_stall_cycles)
    );

    // offer one request and hold it until it is taken
    task automatic send_request(input logic act, input logic [15:0] a, input logic [15:0] b);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {b, a};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // drop valid for some cycles, with junk on the data lines
    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= 1'($urandom);
            s_axis_tdata  <= $urandom;
            repeat (cycles - 1) @(posedge i_clk);
        end
    endtask

    // mostly no gap, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // field element with extra weight on the corner values
    function automatic logic [15:0] pick_operand();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hffff;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random ready pattern, plus one long hold when the burst asks for it
    initial begin
        int r;
        int len;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                long_hold_on = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                long_hold_done = 1'b1;
                long_hold_on   = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                @(negedge i_clk);
                if (r < 55) begin
                    m_axis_tready <= 1'b1;
                    len = $urandom_range(1, 6);
                end else if (r < 85) begin
                    m_axis_tready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else if (r < 93) begin
                    m_axis_tready <= 1'b0;
                    len = $urandom_range(10, 40);
                end else begin
                    m_axis_tready <= 1'b1;
                    len = $urandom_range(30, 80);
                end
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    // run limit
    initial begin
        #10_000_000;
        $display("tb_gf2_16_mul_inv_unit: done, errors");
        $finish;
    end

    // stimulus and verdict
    initial begin
        logic act;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = gf16mi_pkg::ACT_MUL;
        s_axis_tdata  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner products, including ones that need reduction
        send_request(gf16mi_pkg::ACT_MUL, 16'h0000, 16'h0000);
        send_request(gf16mi_pkg::ACT_MUL, 16'hffff, 16'hffff);
        send_request(gf16mi_pkg::ACT_MUL, 16'h0001, 16'hffff);
        send_request(gf16mi_pkg::ACT_MUL, 16'hffff, 16'h0001);
        send_request(gf16mi_pkg::ACT_MUL, 16'h0000, 16'hffff);
        send_request(gf16mi_pkg::ACT_MUL, 16'hffff, 16'h0000);
        send_request(gf16mi_pkg::ACT_MUL, 16'h8000, 16'h0002);
        send_request(gf16mi_pkg::ACT_MUL, 16'h0002, 16'h8000);
        send_request(gf16mi_pkg::ACT_MUL, 16'h8000, 16'h8000);
        send_request(gf16mi_pkg::ACT_MUL, 16'haaaa, 16'h5555);
        // inverses: zero maps to zero, one to one, operand b must not matter
        send_request(gf16mi_pkg::ACT_INV, 16'h0000, 16'h0000);
        send_request(gf16mi_pkg::ACT_INV, 16'h0000, 16'hffff);
        send_request(gf16mi_pkg::ACT_INV, 16'h0001, 16'h0000);
        send_request(gf16mi_pkg::ACT_INV, 16'h0001, 16'hffff);
        send_request(gf16mi_pkg::ACT_INV, 16'h0002, 16'h1234);
        send_request(gf16mi_pkg::ACT_INV, 16'h8000, 16'h0000);
        send_request(gf16mi_pkg::ACT_INV, 16'hffff, 16'h0000);
        send_request(gf16mi_pkg::ACT_INV, 16'h002b, 16'hffff);
        send_request(gf16mi_pkg::ACT_INV, 16'h5555, 16'haaaa);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == 400) begin
                // back-to-back burst against a long receiver hold
                sender_gap(1);
                long_hold_req = 1'b1;
                wait (long_hold_on);
                for (int k = 0; k < BURST_OPS; k++) begin
                    act = 1'($urandom);
                    send_request(act, pick_operand(), pick_operand());
                end
                long_hold_req = 1'b0;
                n = n + BURST_OPS;
            end
            if (n >= 800 && n < 802) begin
                // let the pipeline run dry before going on
                sender_gap(1);
                wait (outstanding == 0);
            end
            act = 1'($urandom);
            send_request(act, pick_operand(), pick_operand());
            if (n < 1000 || n >= 1100) begin
                sender_gap(pick_gap());
            end
        end
        sender_gap(1);

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d multiplies and %0d inverses, corner operands included",
                 mul_count, inv_count);
        $display("input held off for %0d cycles under output back-pressure",
                 input_stall_cycles);
        if (fail_count == 0) begin
            $display("tb_gf2_16_mul_inv_unit: done, clean");
        end else begin
            $display("tb_gf2_16_mul_inv_unit: done, errors");
        end
        $finish;
    end

endmodule
